// ===== rtl/div64_pkg.sv =====
`timescale 1ns / 1ps

package div64_pkg;

  // Fixed widths of the channel fields
  localparam int FIELD_W  = 64;
  localparam int ACTION_W = 2;

  // Default datapath width
  localparam int DATA_WIDTH_DEF = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UQUO = 2'd0,
    ACT_UREM = 2'd1,
    ACT_SQUO = 2'd2,
    ACT_SREM = 2'd3
  } act_t;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    act_t act;
    logic n_neg;
    logic d_neg;
    logic d_zero;
  } ctl_t;

endpackage

// ===== rtl/div64_if.sv =====
`timescale 1ns / 1ps

interface div64_req_if;
  import div64_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [FIELD_W-1:0]  dividend;
  logic [FIELD_W-1:0]  divisor;

  modport source (output valid, output action, output dividend, output divisor, input ready);
  modport sink   (input valid, input action, input dividend, input divisor, output ready);
endinterface

interface div64_rsp_if;
  import div64_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] answer;

  modport source (output valid, output answer, input ready);
  modport sink   (input valid, input answer, output ready);
endinterface

// ===== rtl/div64_prep.sv =====
`timescale 1ns / 1ps

module div64_prep #(
  parameter int DATA_WIDTH = div64_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [div64_pkg::ACTION_W-1:0] action,
  input  logic [div64_pkg::FIELD_W-1:0] dividend,
  input  logic [div64_pkg::FIELD_W-1:0] divisor,
  output logic                          vld_o,
  output div64_pkg::ctl_t               ctl_o,
  output logic [DATA_WIDTH-1:0]         nq_o,
  output logic [DATA_WIDTH-1:0]         d_o
);
  import div64_pkg::*;

  logic [DATA_WIDTH-1:0] n_raw;
  logic [DATA_WIDTH-1:0] d_raw;
  logic                  sgn;
  ctl_t                  ctl_next;
  logic [DATA_WIDTH-1:0] n_mag;
  logic [DATA_WIDTH-1:0] d_mag;

  always_comb begin
    n_raw           = dividend[DATA_WIDTH-1:0];
    d_raw           = divisor[DATA_WIDTH-1:0];
    sgn             = action[1];
    ctl_next.act    = act_t'(action);
    ctl_next.n_neg  = sgn & n_raw[DATA_WIDTH-1];
    ctl_next.d_neg  = sgn & d_raw[DATA_WIDTH-1];
    ctl_next.d_zero = (d_raw == '0);
    n_mag           = ctl_next.n_neg ? (~n_raw + 1'b1) : n_raw;
    d_mag           = ctl_next.d_neg ? (~d_raw + 1'b1) : d_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o <= ctl_next;
      nq_o  <= n_mag;
      d_o   <= d_mag;
    end
  end

endmodule

// ===== rtl/div64_step.sv =====
`timescale 1ns / 1ps

// One restoring shift-subtract step: one quotient bit per stage.
// nq holds the dividend bits not yet consumed (high end) and the
// quotient bits made so far (low end).
module div64_step #(
  parameter int DATA_WIDTH = div64_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_i,
  input  div64_pkg::ctl_t       ctl_i,
  input  logic [DATA_WIDTH-1:0] r_i,
  input  logic [DATA_WIDTH-1:0] nq_i,
  input  logic [DATA_WIDTH-1:0] d_i,
  output logic                  vld_o,
  output div64_pkg::ctl_t       ctl_o,
  output logic [DATA_WIDTH-1:0] r_o,
  output logic [DATA_WIDTH-1:0] nq_o,
  output logic [DATA_WIDTH-1:0] d_o
);
  import div64_pkg::*;

  logic [DATA_WIDTH:0]   rs;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;
  logic [DATA_WIDTH-1:0] r_next;
  logic [DATA_WIDTH-1:0] nq_next;

  always_comb begin
    // carry out of the shift is kept as bit W
    rs      = {r_i, nq_i[DATA_WIDTH-1]};
    diff    = rs - {1'b0, d_i};
    take    = ~diff[DATA_WIDTH];
    r_next  = take ? diff[DATA_WIDTH-1:0] : rs[DATA_WIDTH-1:0];
    nq_next = {nq_i[DATA_WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o <= ctl_i;
      r_o   <= r_next;
      nq_o  <= nq_next;
      d_o   <= d_i;
    end
  end

endmodule

// ===== rtl/div64_post.sv =====
`timescale 1ns / 1ps

// Sign fix-up, result select (zero on a zero divisor) and output register.
module div64_post #(
  parameter int DATA_WIDTH = div64_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_i,
  input  div64_pkg::ctl_t               ctl_i,
  input  logic [DATA_WIDTH-1:0]         r_i,
  input  logic [DATA_WIDTH-1:0]         q_i,
  output logic                          vld_o,
  output logic [div64_pkg::FIELD_W-1:0] answer
);
  import div64_pkg::*;

  logic [DATA_WIDTH-1:0] q_neg;
  logic [DATA_WIDTH-1:0] r_neg;
  logic [DATA_WIDTH-1:0] ans;

  always_comb begin
    q_neg = ~q_i + 1'b1;
    r_neg = ~r_i + 1'b1;
    case (ctl_i.act)
      ACT_UQUO: ans = q_i;
      ACT_UREM: ans = r_i;
      ACT_SQUO: ans = (ctl_i.n_neg ^ ctl_i.d_neg) ? q_neg : q_i;
      ACT_SREM: ans = ctl_i.n_neg ? r_neg : r_i;
      default:  ans = '0;
    endcase
    if (ctl_i.d_zero) begin
      ans = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      answer <= FIELD_W'(ans);
    end
  end

endmodule

// ===== rtl/divide_64_signed_unsigned.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Fields                              | Beat
// --------+-----+-------------------------------------+---------------------
// req     | in  | action[1:0], dividend[63:0],        | valid & ready
//         |     | divisor[63:0]                       |
// rsp     | out | answer[63:0]                        | valid & ready
//
// The pipeline has one operand stage (magnitudes), one stage per
// quotient bit, and the fix-up/output register. One beat is taken
// every cycle while the result side keeps up.
// Reset (rst, sync, active high) clears the stage valid bits only.
// A held result stalls all stages together; req.ready drops with it.
module divide_64_signed_unsigned #(
  parameter int DATA_WIDTH = div64_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  div64_req_if.sink  req,
  div64_rsp_if.source rsp
);
  import div64_pkg::*;

  // global advance: output register empty or being drained
  logic adv;

  // stage k holds the item after k quotient bits
  logic                  vld_s [0:DATA_WIDTH];
  ctl_t                  ctl_s [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] r_s   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] d_s   [0:DATA_WIDTH];

  assign adv       = ~rsp.valid | rsp.ready;
  assign req.ready = adv;

  div64_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_i    (req.valid),
    .action   (req.action),
    .dividend (req.dividend),
    .divisor  (req.divisor),
    .vld_o    (vld_s[0]),
    .ctl_o    (ctl_s[0]),
    .nq_o     (nq_s[0]),
    .d_o      (d_s[0])
  );

  // partial remainder starts at zero
  assign r_s[0] = '0;

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    div64_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .vld_i (vld_s[k]),
      .ctl_i (ctl_s[k]),
      .r_i   (r_s[k]),
      .nq_i  (nq_s[k]),
      .d_i   (d_s[k]),
      .vld_o (vld_s[k+1]),
      .ctl_o (ctl_s[k+1]),
      .r_o   (r_s[k+1]),
      .nq_o  (nq_s[k+1]),
      .d_o   (d_s[k+1])
    );
  end

  // after the last step nq holds the quotient; the divisor copy is spent
  div64_post #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_post (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .vld_i  (vld_s[DATA_WIDTH]),
    .ctl_i  (ctl_s[DATA_WIDTH]),
    .r_i    (r_s[DATA_WIDTH]),
    .q_i    (nq_s[DATA_WIDTH]),
    .vld_o  (rsp.valid),
    .answer (rsp.answer)
  );

endmodule
